[rtl/avcc_to_annexb_nal_filter_core_macros.svh]
// Assertion helpers used by the checker file.
`ifndef AVCC_TO_ANNEXB_NAL_FILTER_CORE_MACROS_SVH
`define AVCC_TO_ANNEXB_NAL_FILTER_CORE_MACROS_SVH

// Clocked assertion that is quiet while reset is held.
`define ANF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ANF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/anf_pkg.sv]
`default_nettype none
package anf_pkg;

  // Length prefix size after reset, and its legal range.
  localparam logic [2:0] LEN_SIZE_RESET = 3'd4;
  localparam logic [2:0] LEN_SIZE_MIN   = 3'd1;
  localparam logic [2:0] LEN_SIZE_MAX   = 3'd4;

  // NAL header decoding.
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
  localparam logic [7:0] NAL_SPS       = 8'd7;
  localparam logic [7:0] NAL_PPS       = 8'd8;

  // Start code: long form 00 00 00 01, short form 00 00 01.
  localparam logic [2:0] SC_LEN_NONE  = 3'd0;
  localparam logic [2:0] SC_LEN_SHORT = 3'd3;
  localparam logic [2:0] SC_LEN_LONG  = 3'd4;
  localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
  localparam logic [7:0] SC_LAST_BYTE = 8'h01;

  // Results produced by one input beat, handed from parser to emitter.
  typedef struct packed {
    logic [2:0] sc_len;    // start code bytes ahead of the data byte
    logic       data_en;   // the input byte itself goes out
    logic [7:0] data;
    logic [2:0] n_res;     // total results, 1 to 5
    logic       pkt_end;
    logic       trunc;
  } anf_burst_t;

endpackage
`default_nettype wire

[rtl/anf_parser.sv]
`default_nettype none
module anf_parser
  import anf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       beat_i,       // input beat accepted this cycle
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  input  wire logic [2:0] length_size_i,
  output logic            burst_o,      // this beat causes results
  output anf_burst_t      burst_desc_o
);

  logic        in_payload_q, in_payload_d;
  logic [31:0] accum_q, accum_d;
  logic [2:0]  seen_q, seen_d;
  logic [31:0] remain_q, remain_d;
  logic        at_hdr_q, at_hdr_d;
  logic        keep_q, keep_d;
  logic        sent_q, sent_d;

  logic [2:0]  eff_size;
  logic [31:0] accum_next;
  logic [2:0]  seen_next;
  logic [31:0] remain_next;
  logic [7:0]  nal_type;
  logic        keep_now;
  logic [2:0]  sc_len;
  logic [2:0]  n_data;

  // Out-of-range sizes are clamped into 1..4.
  always_comb begin
    if (length_size_i < LEN_SIZE_MIN) begin
      eff_size = LEN_SIZE_MIN;
    end else if (length_size_i > LEN_SIZE_MAX) begin
      eff_size = LEN_SIZE_MAX;
    end else begin
      eff_size = length_size_i;
    end
  end

  assign accum_next  = {accum_q[23:0], in_byte_i};
  assign seen_next   = 3'(seen_q + 3'd1);
  assign remain_next = 32'(remain_q - 32'd1);
  assign nal_type    = in_byte_i & NAL_TYPE_MASK;

  // Parser next state and the results of this beat.
  always_comb begin
    in_payload_d = in_payload_q;
    accum_d      = accum_q;
    seen_d       = seen_q;
    remain_d     = remain_q;
    at_hdr_d     = at_hdr_q;
    keep_d       = keep_q;
    sent_d       = sent_q;
    keep_now     = 1'b0;
    sc_len       = SC_LEN_NONE;

    if (!in_payload_q) begin
      // Gather one more big-endian length byte.
      accum_d = accum_next;
      seen_d  = seen_next;
      if (seen_next >= eff_size) begin
        if (accum_next != 32'd0) begin
          in_payload_d = 1'b1;
          remain_d     = accum_next;
          at_hdr_d     = 1'b1;
          keep_d       = 1'b0;
        end
        accum_d = 32'd0;
        seen_d  = 3'd0;
      end
    end else begin
      // Payload byte: the first one decides whether the unit is kept.
      keep_now = keep_q;
      if (at_hdr_q) begin
        keep_now = (nal_type != NAL_SPS) && (nal_type != NAL_PPS);
        at_hdr_d = 1'b0;
        if (keep_now) begin
          sc_len = sent_q ? SC_LEN_SHORT : SC_LEN_LONG;
          sent_d = 1'b1;
        end
      end
      keep_d   = keep_now;
      remain_d = remain_next;
      if (remain_next == 32'd0) begin
        in_payload_d = 1'b0;
        keep_d       = 1'b0;
      end
    end
  end

  assign n_data = {2'b00, keep_now};

  // Describe the burst; an end-only marker stands in when nothing else goes out.
  always_comb begin
    burst_desc_o.sc_len  = sc_len;
    burst_desc_o.data_en = keep_now;
    burst_desc_o.data    = in_byte_i;
    burst_desc_o.pkt_end = in_last_i;
    burst_desc_o.trunc   = in_payload_d || (seen_d != 3'd0);
    if (keep_now) begin
      burst_desc_o.n_res = 3'(sc_len + n_data);
    end else begin
      burst_desc_o.n_res = 3'd1;
    end
  end

  assign burst_o = keep_now || in_last_i;

  // Parser state; packet end returns it to the reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      accum_q      <= 32'd0;
      seen_q       <= 3'd0;
      remain_q     <= 32'd0;
      at_hdr_q     <= 1'b0;
      keep_q       <= 1'b0;
      sent_q       <= 1'b0;
    end else if (beat_i) begin
      if (in_last_i) begin
        in_payload_q <= 1'b0;
        accum_q      <= 32'd0;
        seen_q       <= 3'd0;
        remain_q     <= 32'd0;
        at_hdr_q     <= 1'b0;
        keep_q       <= 1'b0;
        sent_q       <= 1'b0;
      end else begin
        in_payload_q <= in_payload_d;
        accum_q      <= accum_d;
        seen_q       <= seen_d;
        remain_q     <= remain_d;
        at_hdr_q     <= at_hdr_d;
        keep_q       <= keep_d;
        sent_q       <= sent_d;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/anf_emitter.sv]
`default_nettype none
module anf_emitter
  import anf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,       // store a new burst
  input  wire anf_burst_t  burst_desc_i,
  output logic             load_ready_o, // the burst register is free this cycle
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             has_byte_o,
  output logic             run_last_o,
  output logic             packet_end_o,
  output logic             truncated_o
);

  anf_burst_t desc_q;
  logic       valid_q;
  logic [2:0] idx_q;
  logic       is_last;
  logic       take;

  assign is_last      = (3'(idx_q + 3'd1) == desc_q.n_res);
  assign take         = valid_q && out_ready_i;
  assign load_ready_o = !valid_q || (take && is_last);

  // Select the result at the current position of the burst.
  always_comb begin
    if (idx_q < desc_q.sc_len) begin
      out_byte_o = (3'(idx_q + 3'd1) == desc_q.sc_len) ? SC_LAST_BYTE : SC_ZERO_BYTE;
      has_byte_o = 1'b1;
    end else if (desc_q.data_en) begin
      out_byte_o = desc_q.data;
      has_byte_o = 1'b1;
    end else begin
      out_byte_o = SC_ZERO_BYTE;
      has_byte_o = 1'b0;
    end
  end

  assign out_valid_o  = valid_q;
  assign run_last_o   = is_last;
  assign packet_end_o = is_last && desc_q.pkt_end;
  assign truncated_o  = is_last && desc_q.pkt_end && desc_q.trunc;

  // Burst register and position counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 3'd0;
    end else if (load_ready_o) begin
      valid_q <= load_i;
      idx_q   <= 3'd0;
    end else if (take) begin
      idx_q <= 3'(idx_q + 3'd1);
    end
  end

  // Payload of the burst needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_i) begin
      desc_q <= burst_desc_i;
    end
  end

endmodule
`default_nettype wire

[rtl/avcc_to_annexb_nal_filter_core.sv]
// The first result of a byte is offered in the cycle after the byte is accepted.
// One byte per cycle while out_ready_i is high; the first byte of a kept unit gives
// 4 or 5 results; input waits while the single register drains one result per cycle.
// Reset (rst_ni low, asynchronous) clears the parser and the burst register and
// sets the length size register to 4.
`default_nettype none
module avcc_to_annexb_nal_filter_core
  import anf_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            has_byte_o,
  output logic            run_last_o,
  output logic            packet_end_o,
  output logic            truncated_o
);

  logic [2:0] length_size_q;
  logic       beat;
  logic       burst;
  logic       load_ready;
  anf_burst_t burst_desc;

  // Length size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_size_q <= LEN_SIZE_RESET;
    end else if (cfg_we_i) begin
      length_size_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = load_ready;
  assign beat       = in_valid_i && load_ready;

  anf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .length_size_i(length_size_q),
    .burst_o      (burst),
    .burst_desc_o (burst_desc)
  );

  anf_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (beat && burst),
    .burst_desc_i (burst_desc),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .run_last_o   (run_last_o),
    .packet_end_o (packet_end_o),
    .truncated_o  (truncated_o)
  );

endmodule
`default_nettype wire

[rtl/anf_checker.sv]
`default_nettype none
`include "avcc_to_annexb_nal_filter_core_macros.svh"
module anf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       has_byte_o,
  input wire logic       run_last_o,
  input wire logic       packet_end_o,
  input wire logic       truncated_o
);

  // A stalled result beat stays offered.
  `ANF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result beat dropped")

  // The end of a packet closes the run of the byte that caused it.
  `ANF_ASSERT(a_end_run, out_valid_o && packet_end_o |-> run_last_o,
              "packet end without run end")

  // Truncation is reported only on the packet end beat.
  `ANF_ASSERT(a_trunc_end, out_valid_o && truncated_o |-> packet_end_o,
              "truncated outside packet end")

  // An empty beat is the end-only marker and carries a zero byte.
  `ANF_ASSERT(a_marker, out_valid_o && !has_byte_o |->
              out_byte_o == 8'h00 && packet_end_o && run_last_o, "bad end-only marker")

  // Nothing is offered while reset is held.
  `ANF_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind avcc_to_annexb_nal_filter_core anf_checker u_anf_checker (.*);
`default_nettype wire

[test/avcc_to_annexb_nal_filter_core_tb.sv]
`default_nettype none
module avcc_to_annexb_nal_filter_core_tb
  import anf_pkg::*;
;

  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned END_CYCLES      = 20;
  localparam int unsigned MAX_REPORTS     = 40;
  localparam int unsigned PHASE_BEATS     = 14;

  // One output beat: Annex B byte plus its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       run_last;
    logic       pkt_end;
    logic       trunc;
  } annexb_res_t;

  typedef enum logic { ROW_BEAT, ROW_CFG } dir_row_kind_e;

  typedef struct packed {
    dir_row_kind_e kind;
    logic [7:0]    data;     // input byte, or length size for a register write
    logic          last;
    logic          pinned;   // the last result of this beat is typed in below
    annexb_res_t   want;
  } dir_row_t;

  localparam annexb_res_t NO_PIN = '0;

  // Directed stimulus. Pinned rows give the final result of that beat.
  localparam dir_row_t DIR_ROWS [27] = '{
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_CFG,  8'h01, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{ROW_BEAT, 8'h05, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_BEAT, 8'h02, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h65, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_BEAT, 8'h01, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h67, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h01, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h68, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h01, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h41, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h03, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h80, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{ROW_BEAT, 8'hff, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h87, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h12, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_CFG,  8'h04, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h00, 1'b0, 1'b0, NO_PIN},
    '{ROW_CFG,  8'h02, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'h01, 1'b0, 1'b0, NO_PIN},
    '{ROW_BEAT, 8'hff, 1'b1, 1'b0, NO_PIN}
  };

  // Length size for each random phase; every register value shows up once.
  localparam logic [2:0] PHASE_SIZES [8] = '{3'd2, 3'd1, 3'd0, 3'd4, 3'd7, 3'd3, 3'd5, 3'd6};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [2:0] cfg_wdata_i = 3'd0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       has_byte_o;
  logic       run_last_o;
  logic       packet_end_o;
  logic       truncated_o;

  avcc_to_annexb_nal_filter_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .run_last_o   (run_last_o),
    .packet_end_o (packet_end_o),
    .truncated_o  (truncated_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the parser and the length size register.
  logic [2:0]  len_size_shadow = LEN_SIZE_RESET;
  logic        nal_in_payload  = 1'b0;
  logic [31:0] len_accum       = '0;
  logic [2:0]  len_seen        = '0;
  logic [31:0] nal_remaining   = '0;
  logic        at_nal_header   = 1'b0;
  logic        keep_nal        = 1'b0;
  logic        nal_sent_in_pkt = 1'b0;

  annexb_res_t expected_annexb_q [$];
  annexb_res_t last_predicted;
  annexb_res_t seen_res;
  annexb_res_t want_res;
  logic [7:0]  nal_pkt_q [$];

  int unsigned fail_count   = 0;
  int unsigned beats_sent   = 0;
  int unsigned idle_cycles  = 0;
  bit          quiet_phase  = 1'b0;
  bit          hold_off_req = 1'b0;
  bit          hold_active  = 1'b0;

  function automatic void flag_mismatch(input string what, input logic [11:0] want,
                                        input logic [11:0] got);
    if (fail_count < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
    fail_count++;
  endfunction

  // Register values 0 and 5..7 fall back to the nearest legal size.
  function automatic int unsigned eff_len_size(input logic [2:0] v);
    if (v < LEN_SIZE_MIN) return 32'(LEN_SIZE_MIN);
    if (v > LEN_SIZE_MAX) return 32'(LEN_SIZE_MAX);
    return 32'(v);
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Work out the Annex B beats that one accepted input byte produces.
  task automatic predict_annexb_bytes(input logic [7:0] b, input logic last);
    annexb_res_t burst [0:4];
    int          n;
    logic        trunc;
    n = 0;
    if (!nal_in_payload) begin
      len_accum = {len_accum[23:0], b};
      len_seen  = len_seen + 3'd1;
      if (len_seen >= eff_len_size(len_size_shadow)) begin
        // A zero length is skipped and the next length starts right away.
        if (len_accum != 0) begin
          nal_in_payload = 1'b1;
          nal_remaining  = len_accum;
          at_nal_header  = 1'b1;
          keep_nal       = 1'b0;
        end
        len_accum = '0;
        len_seen  = '0;
      end
    end else begin
      if (at_nal_header) begin
        keep_nal      = ((b & NAL_TYPE_MASK) != NAL_SPS) && ((b & NAL_TYPE_MASK) != NAL_PPS);
        at_nal_header = 1'b0;
        if (keep_nal) begin
          // The first unit sent in a packet gets the long start code.
          if (!nal_sent_in_pkt) begin
            burst[n] = {SC_ZERO_BYTE, 4'b1000};
            n++;
          end
          repeat (2) begin
            burst[n] = {SC_ZERO_BYTE, 4'b1000};
            n++;
          end
          burst[n] = {SC_LAST_BYTE, 4'b1000};
          n++;
          nal_sent_in_pkt = 1'b1;
        end
      end
      if (keep_nal) begin
        burst[n] = {b, 4'b1000};
        n++;
      end
      nal_remaining = nal_remaining - 32'd1;
      if (nal_remaining == 0) begin
        nal_in_payload = 1'b0;
        keep_nal       = 1'b0;
      end
    end

    // Packet end closes the burst, or sends a lone marker, and clears the parser.
    if (last) begin
      trunc = nal_in_payload || (len_seen != 0);
      if (n == 0) begin
        burst[n] = '0;
        n++;
      end
      burst[n-1].pkt_end = 1'b1;
      burst[n-1].trunc   = trunc;
      nal_in_payload  = 1'b0;
      len_accum       = '0;
      len_seen        = '0;
      nal_remaining   = '0;
      at_nal_header   = 1'b0;
      keep_nal        = 1'b0;
      nal_sent_in_pkt = 1'b0;
    end

    if (n > 0) begin
      burst[n-1].run_last = 1'b1;
      last_predicted = burst[n-1];
    end else begin
      last_predicted = NO_PIN;
    end
    for (int i = 0; i < n; i++) expected_annexb_q.push_back(burst[i]);
  endtask

  // Offer one beat; valid stays up until it is taken, then maybe a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_annexb_bytes(b, last);
    beats_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every pending result has come out.
  task automatic drain_annexb();
    in_valid_i <= 1'b0;
    while (expected_annexb_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length_size(input logic [2:0] v);
    drain_annexb();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    len_size_shadow = v;
  endtask

  // Append one length-prefixed NAL unit to the packet under construction.
  task automatic add_nal_unit(input int unsigned len, input logic [7:0] hdr);
    for (int k = int'(eff_len_size(len_size_shadow)) - 1; k >= 0; k--) begin
      nal_pkt_q.push_back(8'(len >> (8 * k)));
    end
    if (len != 0) begin
      nal_pkt_q.push_back(hdr);
      repeat (len - 1) nal_pkt_q.push_back(8'($urandom));
    end
  endtask

  task automatic send_nal_packet(input int unsigned cut);
    for (int i = 0; i < cut; i++) send_byte(nal_pkt_q[i], i == cut - 1);
  endtask

  // Mostly well-formed packets; some are cut short, a few are plain noise.
  task automatic send_random_packet();
    int unsigned mode;
    int unsigned r;
    int unsigned len;
    int unsigned cut;
    logic [4:0]  nal_type;
    nal_pkt_q.delete();
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      repeat ($urandom_range(1, 8)) nal_pkt_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        r   = $urandom_range(0, 19);
        len = (r == 0) ? 0 : (r == 1) ? $urandom_range(16, 40) : $urandom_range(1, 6);
        r   = $urandom_range(0, 9);
        nal_type = (r < 3) ? NAL_SPS[4:0] : (r < 5) ? NAL_PPS[4:0] : 5'($urandom);
        add_nal_unit(len, {3'($urandom), nal_type});
      end
    end
    cut = nal_pkt_q.size();
    if (mode <= 2) cut = $urandom_range(1, nal_pkt_q.size());
    send_nal_packet(cut);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_active = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_active  = 1'b0;
        hold_off_req = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = pick_gap();
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // Compare each output beat with the oldest pending expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = {out_byte_o, has_byte_o, run_last_o, packet_end_o, truncated_o};
      if (expected_annexb_q.size() == 0) begin
        flag_mismatch("result with nothing pending:", NO_PIN, seen_res);
      end else begin
        want_res = expected_annexb_q.pop_front();
        if (seen_res.data !== want_res.data) begin
          flag_mismatch("out_byte", 12'(want_res.data), 12'(seen_res.data));
        end
        if (seen_res.has !== want_res.has) begin
          flag_mismatch("has_byte", 12'(want_res.has), 12'(seen_res.has));
        end
        if (seen_res.run_last !== want_res.run_last) begin
          flag_mismatch("run_last", 12'(want_res.run_last), 12'(seen_res.run_last));
        end
        if (seen_res.pkt_end !== want_res.pkt_end) begin
          flag_mismatch("packet_end", 12'(want_res.pkt_end), 12'(seen_res.pkt_end));
        end
        if (seen_res.trunc !== want_res.trunc) begin
          flag_mismatch("truncated", 12'(want_res.trunc), 12'(seen_res.trunc));
        end
      end
    end
  end

  // Watchdog: too many cycles with no beat on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, then random phases per length size.
  initial begin
    int unsigned phase_end;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 27; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_length_size(DIR_ROWS[i].data[2:0]);
      end else begin
        send_byte(DIR_ROWS[i].data, DIR_ROWS[i].last);
        if (DIR_ROWS[i].pinned && last_predicted !== DIR_ROWS[i].want) begin
          flag_mismatch("directed row", DIR_ROWS[i].want, last_predicted);
        end
      end
    end

    for (int p = 0; p < 8; p++) begin
      write_length_size(PHASE_SIZES[p]);
      quiet_phase = (p == 3);
      if (p == 1) begin
        // Long kept unit sent back to back while the receiver holds off.
        hold_off_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
        quiet_phase = 1'b1;
        nal_pkt_q.delete();
        add_nal_unit(14, 8'h65);
        send_nal_packet(nal_pkt_q.size());
        quiet_phase = 1'b0;
      end
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) send_random_packet();
    end
    quiet_phase = 1'b0;

    drain_annexb();
    repeat (END_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_annexb_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[avcc_to_annexb_nal_filter_core.f]
+incdir+rtl
rtl/anf_pkg.sv
rtl/anf_parser.sv
rtl/anf_emitter.sv
rtl/avcc_to_annexb_nal_filter_core.sv
rtl/anf_checker.sv
test/avcc_to_annexb_nal_filter_core_tb.sv
